[hw/rtl/ptc_pkg.sv]
// Package for the pressure/temperature compensation block: calibration
// register indexes, the calibration word struct and the fixed constants.
// No dependencies.
package ptc_pkg;

  localparam int unsigned CAL_W   = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned TOUT_W  = 15;
  localparam int unsigned PRES_W  = 18;
  localparam int unsigned TEMP_W  = 20;
  localparam int unsigned NSTG    = 7;

  typedef enum logic [CIDX_W-1:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } cal_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_slope;
  } cal_t;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -20'sd1500;
  localparam logic signed [TOUT_W-1:0] TEMP_MIN  = -15'sd4000;
  localparam logic signed [TOUT_W-1:0] TEMP_MAX  = 15'sd8500;

  localparam logic [1:0] T2_LO_K  = 2'd3;
  localparam logic [2:0] T2_HI_K  = 3'd5;
  localparam logic [5:0] OFF2_K   = 6'd61;
  localparam logic [4:0] SENS2_K  = 5'd29;
  localparam logic [4:0] OFF3_K   = 5'd17;
  localparam logic [3:0] SENS3_K  = 4'd9;

endpackage

[hw/rtl/pressure_temp_compensation.sv]
// Top level of the barometric second-order compensation pipeline.
// Depends on ptc_pkg and ptc_cal_regs.
//
// Usage:
// - Input channel: raw_pressure_i / raw_temperature_i with in_valid_i and
//   in_stall_o; a word is taken at a clock edge with valid high, stall low.
// - Output channel: temperature_centi_o (0.01 degC, signed, saturated to
//   -4000..8500) and pressure_pa_o (Pa, saturated to 0..262143) with
//   out_valid_o and out_stall_i.
// - Calibration words C1..C6 are written over cfg_we_i / cfg_idx_i /
//   cfg_wdata_i at indexes 0..5; other indexes are ignored. Write them only
//   while no word is in flight.
// - The path from input to output runs through seven register stages:
//   offset, four products, first-order terms, squares, second-order terms,
//   split pressure product, final scale and saturation.
// - Throughput is one word per cycle while the receiver does not stall; each stage holds one word.
// - When the receiver stalls, the output word holds and empty stages keep
//   filling; in_stall_o rises only once all seven stages hold a word.
// - Reset clears the calibration words to zero and empties the pipeline.
module pressure_temp_compensation import ptc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CIDX_W-1:0]        cfg_idx_i,
  input  logic [CAL_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [RAW_W-1:0]         raw_pressure_i,
  input  logic [RAW_W-1:0]         raw_temperature_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [TOUT_W-1:0] temperature_centi_o,
  output logic [PRES_W-1:0]        pressure_pa_o
);

  cal_t cal;

  ptc_cal_regs u_cal (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cal_o       (cal)
  );

  logic [NSTG-1:0] v_q, v_d;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = !out_stall_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    if (rdy[0]) begin
      v_d[0] = in_valid_i;
    end else begin
      v_d[0] = v_q[0];
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NSTG-1];

  // stage 1: dT
  logic signed [24:0]  dt_d, dt_q;
  logic [RAW_W-1:0]    d1_s1_q;

  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, cal.reference_temperature, 8'h00});

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dt_q    <= dt_d;
      d1_s1_q <= raw_pressure_i;
    end
  end

  // stage 2: products with dT
  logic signed [41:0]  p6_d, p4_d, p3_d, p6_q, p4_q, p3_q;
  logic signed [49:0]  sqf_d;
  logic [48:0]         sq_q;
  logic [RAW_W-1:0]    d1_s2_q;

  assign p6_d  = dt_q * $signed({1'b0, cal.temperature_slope});
  assign p4_d  = dt_q * $signed({1'b0, cal.offset_temp_coeff});
  assign p3_d  = dt_q * $signed({1'b0, cal.sensitivity_temp_coeff});
  assign sqf_d = dt_q * dt_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      p6_q    <= p6_d;
      p4_q    <= p4_d;
      p3_q    <= p3_d;
      sq_q    <= sqf_d[48:0];
      d1_s2_q <= d1_s1_q;
    end
  end

  // stage 3: TEMP, OFF, SENS, T2
  logic signed [41:0]       p6_sh, p4_sh, p3_sh;
  logic signed [TEMP_W-1:0] temp_d, temp_q;
  logic signed [36:0]       off_d, off_s3_q;
  logic signed [35:0]       sens_d, sens_s3_q;
  logic [50:0]              t2lo_f;
  logic [51:0]              t2hi_f;
  logic [16:0]              t2_d, t2_q;
  logic                     lo_d, lo_s3_q;
  logic [RAW_W-1:0]         d1_s3_q;

  assign p6_sh  = p6_q >>> 23;
  assign p4_sh  = p4_q >>> 6;
  assign p3_sh  = p3_q >>> 7;
  assign temp_d = $signed(p6_sh[TEMP_W-1:0]) + TEMP_REF;
  assign off_d  = $signed({4'b0, cal.pressure_offset, 17'b0}) + $signed(p4_sh[36:0]);
  assign sens_d = $signed({4'b0, cal.pressure_sensitivity, 16'b0}) + $signed(p3_sh[35:0]);
  assign lo_d   = temp_d < TEMP_REF;
  assign t2lo_f = sq_q * T2_LO_K;
  assign t2hi_f = sq_q * T2_HI_K;
  assign t2_d   = lo_d ? t2lo_f[49:33] : {3'b0, t2hi_f[51:38]};

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      temp_q    <= temp_d;
      off_s3_q  <= off_d;
      sens_s3_q <= sens_d;
      t2_q      <= t2_d;
      lo_s3_q   <= lo_d;
      d1_s3_q   <= d1_s2_q;
    end
  end

  // stage 4: squares of the temperature offsets, output temperature
  logic signed [TEMP_W-1:0] dtemp, etemp;
  logic signed [39:0]       sqd_f, sqe_f;
  logic signed [20:0]       tdiff;
  logic [33:0]              sqd_q, sqe_q;
  logic signed [TOUT_W-1:0] tout_d, tout_s4_q;
  logic                     vlow_d, vlow_q, lo_s4_q;
  logic signed [36:0]       off_s4_q;
  logic signed [35:0]       sens_s4_q;
  logic [RAW_W-1:0]         d1_s4_q;

  assign dtemp  = temp_q - TEMP_REF;
  assign etemp  = temp_q - TEMP_VLOW;
  assign sqd_f  = dtemp * dtemp;
  assign sqe_f  = etemp * etemp;
  assign vlow_d = temp_q < TEMP_VLOW;
  assign tdiff  = {temp_q[TEMP_W-1], temp_q} - $signed({4'b0, t2_q});

  always_comb begin
    if (tdiff < TEMP_MIN) begin
      tout_d = TEMP_MIN;
    end else if (tdiff > TEMP_MAX) begin
      tout_d = TEMP_MAX;
    end else begin
      tout_d = tdiff[TOUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      sqd_q     <= sqd_f[33:0];
      sqe_q     <= sqe_f[33:0];
      vlow_q    <= vlow_d;
      lo_s4_q   <= lo_s3_q;
      tout_s4_q <= tout_d;
      off_s4_q  <= off_s3_q;
      sens_s4_q <= sens_s3_q;
      d1_s4_q   <= d1_s3_q;
    end
  end

  // stage 5: OFF2, SENS2 and corrected OFF, SENS
  logic [39:0]              off2a, off2_d;
  logic [38:0]              off2b, sens2a;
  logic [37:0]              sens2b, sens2_d;
  logic signed [41:0]       offc_d, offc_s5_q;
  logic signed [39:0]       sensc_d, sensc_q;
  logic signed [TOUT_W-1:0] tout_s5_q;
  logic [RAW_W-1:0]         d1_s5_q;

  assign off2a  = sqd_q * OFF2_K;
  assign off2b  = sqe_q * OFF3_K;
  assign sens2a = sqd_q * SENS2_K;
  assign sens2b = sqe_q * SENS3_K;

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    if (lo_s4_q) begin
      off2_d  = off2a >> 4;
      sens2_d = {3'b0, sens2a[38:4]};
      if (vlow_q) begin
        off2_d  = off2_d + {1'b0, off2b};
        sens2_d = sens2_d + sens2b;
      end
    end
  end

  assign offc_d  = $signed({{5{off_s4_q[36]}}, off_s4_q}) - $signed({2'b0, off2_d});
  assign sensc_d = $signed({{4{sens_s4_q[35]}}, sens_s4_q}) - $signed({2'b0, sens2_d});

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      offc_s5_q <= offc_d;
      sensc_q   <= sensc_d;
      tout_s5_q <= tout_s4_q;
      d1_s5_q   <= d1_s4_q;
    end
  end

  // stage 6: D1 * SENS as two partial products
  logic [44:0]              pl_d, pl_q;
  logic signed [43:0]       ph_d, ph_q;
  logic signed [41:0]       offc_s6_q;
  logic signed [TOUT_W-1:0] tout_s6_q;

  assign pl_d = d1_s5_q * sensc_q[20:0];
  assign ph_d = $signed({1'b0, d1_s5_q}) * $signed(sensc_q[39:21]);

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      pl_q      <= pl_d;
      ph_q      <= ph_d;
      offc_s6_q <= offc_s5_q;
      tout_s6_q <= tout_s5_q;
    end
  end

  // stage 7: scale, subtract OFF, saturate
  logic signed [45:0]       acc, pr_sh;
  logic [PRES_W-1:0]        pres_d, pres_q;
  logic signed [TOUT_W-1:0] tout_q;

  assign acc = $signed({{2{ph_q[43]}}, ph_q}) + $signed({22'b0, pl_q[44:21]})
             - $signed({{4{offc_s6_q[41]}}, offc_s6_q});
  assign pr_sh = acc >>> 15;

  always_comb begin
    if (pr_sh[45]) begin
      pres_d = '0;
    end else if (|pr_sh[44:PRES_W]) begin
      pres_d = '1;
    end else begin
      pres_d = pr_sh[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      pres_q <= pres_d;
      tout_q <= tout_s6_q;
    end
  end

  assign temperature_centi_o = tout_q;
  assign pressure_pa_o       = pres_q;

  a_no_stall_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&v_q) |-> !in_stall_o)
    else $error("input stalled while a stage is empty");

  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted word did not enter the first stage");

  a_advance_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NSTG-2] && !out_stall_i |=> out_valid_o)
    else $error("word lost before the output stage");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (temperature_centi_o >= TEMP_MIN && temperature_centi_o <= TEMP_MAX))
    else $error("temperature outside saturation range");

endmodule

[hw/rtl/ptc_cal_regs.sv]
// Calibration word register file for the compensation block.
// Decodes the plain write port into the six words. Depends on ptc_pkg.
module ptc_cal_regs import ptc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CAL_W-1:0]  cfg_wdata_i,
  output cal_t              cal_o
);

  cal_t cal_d, cal_q;

  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      unique case (cal_idx_e'(cfg_idx_i))
        REG_C1:  cal_d.pressure_sensitivity   = cfg_wdata_i;
        REG_C2:  cal_d.pressure_offset        = cfg_wdata_i;
        REG_C3:  cal_d.sensitivity_temp_coeff = cfg_wdata_i;
        REG_C4:  cal_d.offset_temp_coeff      = cfg_wdata_i;
        REG_C5:  cal_d.reference_temperature  = cfg_wdata_i;
        REG_C6:  cal_d.temperature_slope      = cfg_wdata_i;
        default: cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

[test/tb.sv]
// Testbench for pressure_temp_compensation: random and directed raw pairs under
// several calibration sets, checked word by word against an in-bench predictor.
// Depends on ptc_pkg and the pressure_temp_compensation RTL.
`timescale 1ns / 1ps

module tb;
  import ptc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CIDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CIDX_W-1:0] IDX_SPARE_B = 3'd7;

  typedef struct packed {
    logic [RAW_W-1:0] pres;
    logic [RAW_W-1:0] temp;
  } raw_word_t;

  typedef struct packed {
    logic signed [TOUT_W-1:0] temp_centi;
    logic [PRES_W-1:0]        pres_pa;
  } comp_word_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CIDX_W-1:0]        cfg_idx_i = '0;
  logic [CAL_W-1:0]         cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [RAW_W-1:0]         raw_pressure_i = '0;
  logic [RAW_W-1:0]         raw_temperature_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [TOUT_W-1:0] temperature_centi_o;
  logic [PRES_W-1:0]        pressure_pa_o;

  raw_word_t  pending_words[$];
  comp_word_t expected_words[$];
  cal_t       cal_q = '0;
  logic       in_acc = 1'b0;
  int         error_count = 0;
  int         idle_cycles = 0;
  int         gap_left = 0;
  int         burst_left = 1;
  logic [15:0] stall_pat = '0;
  logic [5:0]  stall_phase = '0;

  pressure_temp_compensation dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .raw_pressure_i      (raw_pressure_i),
    .raw_temperature_i   (raw_temperature_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temperature_centi_o),
    .pressure_pa_o       (pressure_pa_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic comp_word_t compensate(input logic [RAW_W-1:0] d1_raw,
                                            input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, off2, sens2, pres, tout, dtemp, e;
    comp_word_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    c1 = cal_q.pressure_sensitivity;
    c2 = cal_q.pressure_offset;
    c3 = cal_q.sensitivity_temp_coeff;
    c4 = cal_q.offset_temp_coeff;
    c5 = cal_q.reference_temperature;
    c6 = cal_q.temperature_slope;
    dt = d2 - c5 * 256;
    temp = 2000 + ((dt * c6) >>> 23);
    off = c2 * 131072 + ((c4 * dt) >>> 6);
    sens = c1 * 65536 + ((c3 * dt) >>> 7);
    if (temp < 2000) begin
      dtemp = temp - 2000;
      t2 = (3 * dt * dt) >>> 33;
      off2 = (61 * dtemp * dtemp) >>> 4;
      sens2 = (29 * dtemp * dtemp) >>> 4;
      if (temp < -1500) begin
        e = temp + 1500;
        off2 = off2 + 17 * e * e;
        sens2 = sens2 + 9 * e * e;
      end
    end else begin
      t2 = (5 * dt * dt) >>> 38;
      off2 = 0;
      sens2 = 0;
    end
    sens = sens - sens2;
    off = off - off2;
    pres = (((d1 * sens) >>> 21) - off) >>> 15;
    tout = temp - t2;
    if (tout < -4000) tout = -4000;
    if (tout > 8500) tout = 8500;
    if (pres < 0) pres = 0;
    if (pres > 262143) pres = 262143;
    r.temp_centi = tout[TOUT_W-1:0];
    r.pres_pa = pres[PRES_W-1:0];
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] d2_at(input cal_t c, input longint dt);
    longint v;
    v = longint'(c.reference_temperature) * 256 + dt;
    if (v < 0) v = 0;
    if (v > 16777215) v = 16777215;
    return v[RAW_W-1:0];
  endfunction

  // raw temperature whose first-order TEMP lands near the target; a random one when the slope word is zero
  function automatic logic [RAW_W-1:0] raw_temp_for(input cal_t c, input int target);
    longint dt;
    if (c.temperature_slope == 0)
      dt = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    else
      dt = (longint'(target) - 2000) * 8388608 / longint'(c.temperature_slope);
    return d2_at(c, dt);
  endfunction

  function automatic raw_word_t rand_word(input cal_t c);
    raw_word_t w;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) w.pres = '0;
    else if (sel == 1) w.pres = '1;
    else w.pres = RAW_W'($urandom);
    sel = $urandom_range(0, 9);
    if (sel == 0) w.temp = '0;
    else if (sel == 1) w.temp = '1;
    else if (sel < 5) w.temp = RAW_W'($urandom);
    else w.temp = raw_temp_for(c, int'($urandom_range(0, 18000)) - 7000);
    return w;
  endfunction

  function automatic cal_t rand_cal();
    cal_t c;
    c.pressure_sensitivity = CAL_W'($urandom);
    c.pressure_offset = CAL_W'($urandom);
    c.sensitivity_temp_coeff = CAL_W'($urandom);
    c.offset_temp_coeff = CAL_W'($urandom);
    c.reference_temperature = CAL_W'($urandom);
    c.temperature_slope = CAL_W'($urandom);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic write_cal(input cal_t c);
    write_reg(REG_C1, c.pressure_sensitivity);
    write_reg(REG_C2, c.pressure_offset);
    write_reg(REG_C3, c.sensitivity_temp_coeff);
    write_reg(REG_C4, c.offset_temp_coeff);
    write_reg(REG_C5, c.reference_temperature);
    write_reg(REG_C6, c.temperature_slope);
    write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, CAL_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CIDX_W'($urandom);
    cfg_wdata_i <= CAL_W'($urandom);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (NSTG + 2) @(posedge clk_i);
  endtask

  // hold the sender halfway until every expected word is back
  task automatic run_random_words(input cal_t c, input int n);
    for (int i = 0; i < n / 2; i++) pending_words.push_back(rand_word(c));
    wait_drained();
    for (int i = n / 2; i < n; i++) pending_words.push_back(rand_word(c));
    wait_drained();
  endtask

  always @(negedge clk_i) begin : driver
    raw_word_t w;
    if (!in_valid_i || in_acc) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
        raw_pressure_i <= RAW_W'($urandom);
        raw_temperature_i <= RAW_W'($urandom);
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_valid_i <= 1'b1;
        raw_pressure_i <= w.pres;
        raw_temperature_i <= w.temp;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
        raw_pressure_i <= RAW_W'($urandom);
        raw_temperature_i <= RAW_W'($urandom);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat <= '0;
        1: stall_pat <= 16'($urandom) & 16'h7fff;
        2: stall_pat <= 16'($urandom | $urandom) & 16'hfffe;
        default: stall_pat <= 16'($urandom & $urandom);
      endcase
    end
    out_stall_i <= stall_pat[stall_phase[3:0]];
    stall_phase <= stall_phase + 6'd1;
  end

  always @(posedge clk_i) begin : monitor
    comp_word_t want;
    if (rst_ni) begin
      in_acc <= in_valid_i && !in_stall_o;
      if (cfg_we_i) begin
        case (cal_idx_e'(cfg_idx_i))
          REG_C1: cal_q.pressure_sensitivity <= cfg_wdata_i;
          REG_C2: cal_q.pressure_offset <= cfg_wdata_i;
          REG_C3: cal_q.sensitivity_temp_coeff <= cfg_wdata_i;
          REG_C4: cal_q.offset_temp_coeff <= cfg_wdata_i;
          REG_C5: cal_q.reference_temperature <= cfg_wdata_i;
          REG_C6: cal_q.temperature_slope <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        expected_words.push_back(compensate(raw_pressure_i, raw_temperature_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, temperature_centi", temperature_centi_o, 0);
        end else begin
          want = expected_words.pop_front();
          if (temperature_centi_o !== want.temp_centi)
            report_mismatch("temperature_centi", temperature_centi_o, want.temp_centi);
          if (pressure_pa_o !== want.pres_pa)
            report_mismatch("pressure_pa", pressure_pa_o, want.pres_pa);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL pressure_temp_compensation");
        $finish;
      end
    end
  end

  initial begin : sequencer
    cal_t c;
    raw_word_t w;
    logic [RAW_W-1:0] dir_temps [10];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset calibration: all words zero
    c = '0;
    run_random_words(c, 60);

    c.pressure_sensitivity = 16'd46372;
    c.pressure_offset = 16'd43981;
    c.sensitivity_temp_coeff = 16'd29059;
    c.offset_temp_coeff = 16'd27842;
    c.reference_temperature = 16'd31553;
    c.temperature_slope = 16'd28165;
    write_cal(c);
    dir_temps[0] = '0;
    dir_temps[1] = '1;
    dir_temps[2] = d2_at(c, 0);
    dir_temps[3] = d2_at(c, -1);
    dir_temps[4] = raw_temp_for(c, -1500);
    dir_temps[5] = raw_temp_for(c, -1501);
    dir_temps[6] = raw_temp_for(c, -4000);
    dir_temps[7] = raw_temp_for(c, 9000);
    dir_temps[8] = raw_temp_for(c, -9000);
    dir_temps[9] = raw_temp_for(c, 1000);
    foreach (dir_temps[k]) begin
      w.temp = dir_temps[k];
      w.pres = '0;
      pending_words.push_back(w);
      w.pres = '1;
      pending_words.push_back(w);
    end
    w.pres = RAW_W'($urandom);
    w.temp = d2_at(c, 1);
    pending_words.push_back(w);
    wait_drained();
    run_random_words(c, 120);

    c = '1;
    write_cal(c);
    run_random_words(c, 100);

    c = '0;
    write_cal(c);
    run_random_words(c, 60);

    c = rand_cal();
    c.temperature_slope = '0;
    c.reference_temperature = '1;
    write_cal(c);
    run_random_words(c, 80);

    c = rand_cal();
    c.reference_temperature = '0;
    write_cal(c);
    run_random_words(c, 100);

    for (int p = 0; p < 3; p++) begin
      c = rand_cal();
      write_cal(c);
      run_random_words(c, 130);
    end

    wait_drained();
    repeat (NSTG * 3) @(posedge clk_i);
    if (error_count == 0 && expected_words.size() == 0)
      $display("PASS pressure_temp_compensation");
    else
      $display("FAIL pressure_temp_compensation");
    $finish;
  end

endmodule

[pressure_temp_compensation.f]
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_cal_regs.sv
hw/rtl/pressure_temp_compensation.sv
test/tb.sv
